### src/spn_pkg.sv
// Shared constants, types and round functions of the 16-bit SPN block cipher.
package spn_pkg;

	localparam int ROUNDS  = 5;
	localparam int BLOCK_W = 16;
	localparam int KEY_W   = 24;
	localparam int NIB_W   = 4;
	localparam int NIBS    = BLOCK_W / NIB_W;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0]   key_t;

	typedef struct packed {
		logic   valid;
		block_t data;
	} stage_t;

	function automatic logic [NIB_W-1:0] sbox(input logic [NIB_W-1:0] x);
		logic [NIB_W-1:0] y;
		case (x)
			4'h0: y = 4'd13;
			4'h1: y = 4'd14;
			4'h2: y = 4'd4;
			4'h3: y = 4'd1;
			4'h4: y = 4'd2;
			4'h5: y = 4'd15;
			4'h6: y = 4'd11;
			4'h7: y = 4'd8;
			4'h8: y = 4'd3;
			4'h9: y = 4'd10;
			4'ha: y = 4'd6;
			4'hb: y = 4'd12;
			4'hc: y = 4'd5;
			4'hd: y = 4'd9;
			4'he: y = 4'd0;
			default: y = 4'd7;
		endcase
		return y;
	endfunction

	function automatic block_t substitute(input block_t x);
		block_t y;
		for (int n = 0; n < NIBS; n++) begin
			y[n*NIB_W +: NIB_W] = sbox(x[n*NIB_W +: NIB_W]);
		end
		return y;
	endfunction

	// 4x4 transpose; bit 0 is the MSB
	function automatic block_t permute(input block_t x);
		block_t y;
		int     q;
		for (int p = 0; p < BLOCK_W; p++) begin
			q = NIBS * (p % NIBS) + p / NIBS;
			y[BLOCK_W-1-p] = x[BLOCK_W-1-q];
		end
		return y;
	endfunction

endpackage

### src/spn_round.sv
// One round cell: key mix, substitution and permutation into a stage register.
module spn_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spn_pkg::stage_t        up,
	output logic                   up_ready,
	input  spn_pkg::block_t        round_key,
	output spn_pkg::stage_t        down,
	input  logic                   down_ready
);

	logic            valid_q;
	spn_pkg::block_t data_q;
	spn_pkg::block_t mixed;

	assign up_ready = !valid_q || down_ready;
	assign mixed    = spn_pkg::permute(spn_pkg::substitute(up.data ^ round_key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			data_q <= mixed;
		end
	end

	assign down.valid = valid_q;
	assign down.data  = data_q;

endmodule

### src/spn_block_encrypt_16bit.sv
// Top level of the 16-bit SPN block cipher: a chain of five round cells.
//
// Input channel: in_valid / in_ready carry plaintext, one transaction per block.
// Output channel: out_valid / out_ready carry ciphertext, one per block, in order.
// Key port: master_key is loaded when master_key_we is high; change it only
// while no block is in flight.
// Each round cell owns one pipeline register, so a block passes through five
// registers on its way out. A new block can be taken in every cycle while the
// receiver keeps up; the rate is set by the one-round logic between cells.
// The last cell is the output register. When the receiver stalls, the held
// result stays put and empty cells upstream keep filling; input stalls only
// once every cell is full.
// Reset clears all cell valid bits and the key to zero; no transaction is
// in flight afterwards.
module spn_block_encrypt_16bit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        master_key_we,
	input  logic [spn_pkg::KEY_W-1:0]   master_key,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [spn_pkg::BLOCK_W-1:0] plaintext,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [spn_pkg::BLOCK_W-1:0] ciphertext
);

	spn_pkg::key_t                  key_q;
	logic [2*spn_pkg::KEY_W-1:0]    key_dbl;
	spn_pkg::stage_t                chain [spn_pkg::ROUNDS+1];
	logic                           ready [spn_pkg::ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (master_key_we) begin
			key_q <= master_key;
		end
	end

	assign key_dbl = {key_q, key_q};

	assign chain[0].valid = in_valid;
	assign chain[0].data  = plaintext;
	assign in_ready       = ready[0];

	for (genvar i = 0; i < spn_pkg::ROUNDS; i++) begin : g_round
		localparam int ROT = (4 * i) % spn_pkg::KEY_W;
		spn_pkg::block_t rk;

		assign rk = key_dbl[2*spn_pkg::KEY_W-1-ROT -: spn_pkg::BLOCK_W];

		spn_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.up         (chain[i]),
			.up_ready   (ready[i]),
			.round_key  (rk),
			.down       (chain[i+1]),
			.down_ready (ready[i+1])
		);
	end

	assign ready[spn_pkg::ROUNDS] = out_ready;
	assign out_valid  = chain[spn_pkg::ROUNDS].valid;
	assign ciphertext = chain[spn_pkg::ROUNDS].data;

endmodule

### src/spn_checker.sv
// Port-level checker for the SPN block cipher, bound to the top level.
module spn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [spn_pkg::BLOCK_W-1:0] ciphertext
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ciphertext))
		else $error("stalled result dropped or changed");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind spn_block_encrypt_16bit spn_checker u_spn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ciphertext (ciphertext)
);

### tb/sv/spn_cipher_checker.sv
// Scoreboard for the 16-bit SPN cipher: predicts each ciphertext and compares it in order.
`timescale 1ns / 1ps

module spn_cipher_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                master_key_we,
	input  spn_pkg::key_t       master_key,
	input  logic                in_valid,
	input  logic                in_ready,
	input  spn_pkg::block_t     plaintext,
	input  logic                out_valid,
	input  logic                out_ready,
	input  spn_pkg::block_t     ciphertext,
	output int                  mismatches,
	output int                  outstanding
);

	// substitution table, entry 0 in the top nibble
	localparam logic [63:0] SUB_TAB = {4'd13, 4'd14, 4'd4, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7};

	spn_pkg::block_t expected_ct[$];
	spn_pkg::key_t   key_copy;
	int              results_seen;

	function automatic spn_pkg::block_t encrypt_block(input spn_pkg::block_t pt,
		input spn_pkg::key_t key);
		spn_pkg::block_t x;
		spn_pkg::block_t rk;
		spn_pkg::block_t subd;
		spn_pkg::block_t perm;
		logic [3:0] nib;
		int src;
		x = pt;
		for (int r = 1; r <= spn_pkg::ROUNDS; r++) begin
			// key bit 0 is the MSB; index wraps over the 24-bit key
			for (int k = 0; k < 16; k++)
				rk[15-k] = key[23 - ((4*r - 4 + k) % 24)];
			x = x ^ rk;
			for (int n = 0; n < 4; n++) begin
				nib = x[15-4*n -: 4];
				subd[15-4*n -: 4] = SUB_TAB[63-4*nib -: 4];
			end
			for (int p = 0; p < 16; p++) begin
				src = 4*(p % 4) + p/4;
				perm[15-p] = subd[15-src];
			end
			x = perm;
		end
		return x;
	endfunction

	task automatic report_mismatch(input string what, input spn_pkg::block_t got,
		input spn_pkg::block_t want);
		$display("MISMATCH result %0d: %s got %h expected %h at %0t",
			results_seen, what, got, want, $realtime);
		mismatches++;
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
		results_seen = 0;
		key_copy = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_copy = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_ct.size() == 0) begin
					report_mismatch("unexpected ciphertext", ciphertext, '0);
				end else begin
					spn_pkg::block_t want;
					want = expected_ct.pop_front();
					if (ciphertext !== want)
						report_mismatch("ciphertext", ciphertext, want);
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				expected_ct = {expected_ct, encrypt_block(plaintext, key_copy)};
			if (master_key_we)
				key_copy = master_key;
			outstanding = expected_ct.size();
		end
	end

endmodule

### tb/sv/tb_spn_block_encrypt_16bit.sv
// Testbench top for the 16-bit SPN cipher: stimulus, key loads, flow control and verdict.
`timescale 1ns / 1ps

module tb_spn_block_encrypt_16bit;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASES       = 8;
	localparam int PHASE_BLOCKS = 220;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            master_key_we;
	spn_pkg::key_t   master_key;
	logic            in_valid;
	logic            in_ready;
	spn_pkg::block_t plaintext;
	logic            out_valid;
	logic            out_ready;
	spn_pkg::block_t ciphertext;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int blocks_sent = 0;
	int keys_loaded = 0;

	spn_block_encrypt_16bit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.master_key_we (master_key_we),
		.master_key    (master_key),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.plaintext     (plaintext),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ciphertext    (ciphertext)
	);

	spn_cipher_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.master_key_we (master_key_we),
		.master_key    (master_key),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.plaintext     (plaintext),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ciphertext    (ciphertext),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// called and returns at a falling edge
	task automatic send_block(input spn_pkg::block_t pt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		plaintext <= pt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		blocks_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic load_key(input spn_pkg::key_t k);
		drain_pipeline();
		repeat (8) @(negedge clk);
		master_key_we <= 1'b1;
		master_key    <= k;
		@(negedge clk);
		master_key_we <= 1'b0;
		keys_loaded++;
	endtask

	initial begin
		spn_pkg::key_t phase_key;
		arst_n        = 1'b0;
		master_key_we = 1'b0;
		master_key    = '0;
		in_valid      = 1'b0;
		plaintext     = '0;
		out_ready     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset key, every nibble value in every position, single bits, alternating bits and ascending nibbles
		for (int v = 0; v < 16; v++)
			send_block({4{v[3:0]}});
		send_block(16'h8000);
		send_block(16'h0001);
		send_block(16'hAAAA);
		send_block(16'h5555);
		send_block(16'h0123);
		send_block(16'hCDEF);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_key = 24'hFFFFFF;
				1: phase_key = 24'h000000;
				2: phase_key = 24'h800001;
				3: phase_key = 24'h7FFFFE;
				default: phase_key = spn_pkg::key_t'($urandom_range(0, 24'hFFFFFF));
			endcase
			load_key(phase_key);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 76; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 76; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			for (int i = 0; i < PHASE_BLOCKS; i++) begin
				if (i == PHASE_BLOCKS/2)
					drain_pipeline();
				send_block(spn_pkg::block_t'($urandom_range(0, 16'hFFFF)));
			end
		end

		drain_pipeline();
		repeat (20) @(negedge clk);
		$display("Encrypted %0d blocks under %0d loaded keys (all-ones, all-zeros, edge and random)",
			blocks_sent, keys_loaded);
		$display("with no flow control, 76%% sender idle, 76%% receiver stall and 36%% of both");
		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### spn_block_encrypt_16bit.f
src/spn_pkg.sv
src/spn_round.sv
src/spn_block_encrypt_16bit.sv
src/spn_checker.sv
tb/sv/spn_cipher_checker.sv
tb/sv/tb_spn_block_encrypt_16bit.sv
